FILE: design/qpw_pkg.sv
// ----------------------------------------------------------------------------
// qpw_pkg: shared types and constants for the winding test
// Coordinate, root and accumulator widths; unit result structs; count step.
// ----------------------------------------------------------------------------
package qpw_pkg;

  localparam int CW  = 24;          // coordinate width
  localparam int TF  = 16;          // root fraction bits
  localparam int WW  = 16;          // winding count width
  localparam int DW  = CW + 1;      // coordinate difference
  localparam int NW  = CW + 3;      // divider operands
  localparam int TW  = TF + 1;      // root in [0, 1]
  localparam int MA  = 2 * TF + 2;  // multiplier operand a
  localparam int MB  = CW + 2;      // multiplier operand b
  localparam int PW  = MA + MB;     // product and accumulator
  localparam int SQW = 2 * DW;      // square root radicand
  localparam int SRW = DW;          // square root result
  localparam int SQ_CNT_W = $clog2(SRW);
  localparam int DV_CNT_W = $clog2(TW);

  localparam logic [TW-1:0] T_ONE = {1'b1, {TF{1'b0}}};
  localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};

  typedef struct packed {
    logic           done;
    logic [SRW-1:0] root;
  } sq_res_t;

  typedef struct packed {
    logic          done;
    logic          ok;
    logic [TW-1:0] q;
  } dv_res_t;

  function automatic logic signed [WW-1:0] wind_step(input logic signed [WW-1:0] w,
                                                     input logic down);
    logic signed [WW-1:0] r;
    if (down) begin
      r = (w == W_MIN) ? w : w - {{(WW-1){1'b0}}, 1'b1};
    end else begin
      r = (w == W_MAX) ? w : w + {{(WW-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

FILE: design/qpw_sqrt.sv
// ----------------------------------------------------------------------------
// qpw_sqrt: iterative integer square root
// Restoring digit recurrence, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module qpw_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [qpw_pkg::SQW-1:0]  value_i,
  output qpw_pkg::sq_res_t         res_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [qpw_pkg::SQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic [qpw_pkg::SQW-1:0]         val_q, val_d;
  logic [qpw_pkg::SRW+1:0]         rem_q, rem_d;
  logic [qpw_pkg::SRW-1:0]         root_q, root_d;
  logic [qpw_pkg::SRW+1:0]         rem2, trial;
  logic                            ge;

  assign rem2  = {rem_q[qpw_pkg::SRW-1:0], val_q[qpw_pkg::SQW-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign ge    = rem2 >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d  = {val_q[qpw_pkg::SQW-3:0], 2'b00};
      rem_d  = ge ? rem2 - trial : rem2;
      root_d = {root_q[qpw_pkg::SRW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == qpw_pkg::SQ_CNT_W'(qpw_pkg::SRW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign res_o.done = done_q;
  assign res_o.root = root_q;

endmodule

FILE: design/qpw_div.sv
// ----------------------------------------------------------------------------
// qpw_div: iterative root divider
// Forms num * 2^TF / den truncated toward zero, one quotient bit a cycle,
// and flags whether the quotient lies in [0, 1].
// ----------------------------------------------------------------------------
module qpw_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [qpw_pkg::NW-1:0]  num_i,
  input  logic signed [qpw_pkg::NW-1:0]  den_i,
  output qpw_pkg::dv_res_t               res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [qpw_pkg::DV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [qpw_pkg::NW-1:0]        dmag_q, dmag_d;
  logic [qpw_pkg::NW-1:0]        rem_q, rem_d;
  logic                          low_q, low_d;
  logic                          bad_q, bad_d;
  logic                          neg_q, neg_d;
  logic [qpw_pkg::TW-1:0]        quo_q, quo_d;
  logic [qpw_pkg::NW-1:0]        nmag, dmag;
  logic [qpw_pkg::NW:0]          rem2, rem_sub;
  logic                          ge;

  assign nmag    = num_i[qpw_pkg::NW-1] ? -num_i : num_i;
  assign dmag    = den_i[qpw_pkg::NW-1] ? -den_i : den_i;
  assign rem2    = {rem_q, (cnt_q == '0) ? low_q : 1'b0};
  assign ge      = rem2 >= {1'b0, dmag_q};
  assign rem_sub = rem2 - {1'b0, dmag_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dmag_d = dmag_q;
    rem_d  = rem_q;
    low_d  = low_q;
    bad_d  = bad_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dmag_d = dmag;
      rem_d  = {1'b0, nmag[qpw_pkg::NW-1:1]};
      low_d  = nmag[0];
      bad_d  = (den_i == '0) || ({1'b0, nmag[qpw_pkg::NW-1:1]} >= dmag);
      neg_d  = num_i[qpw_pkg::NW-1] ^ den_i[qpw_pkg::NW-1];
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[qpw_pkg::NW-1:0] : rem2[qpw_pkg::NW-1:0];
      quo_d = {quo_q[qpw_pkg::TW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == qpw_pkg::DV_CNT_W'(qpw_pkg::TW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dmag_q <= dmag_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    bad_q  <= bad_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
  end

  assign res_o.done = done_q;
  assign res_o.q    = quo_q;
  assign res_o.ok   = !bad_q && (quo_q <= qpw_pkg::T_ONE) && ((quo_q == '0) || !neg_q);

endmodule

FILE: design/quad_path_winding_test.sv
// ----------------------------------------------------------------------------
// quad_path_winding_test: point in path test by winding count
// Lines and quadratic curves, one element per item, verdict on the last one.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i: fill rule
//  s_axis    in   tvalid / tready            tdata: coords, tuser, tlast
//  m_axis    out  tvalid / tready            tdata: inside, winding
//
// Per item: prepare, then for a line the multiply steps, for a curve up to the sqrt loop,
// divider runs, eval steps per root and tangent steps; sqrt and divider loops dominate.
// One shared multiplier feeds an accumulator under the sequencer.
// Reset clears the count, fill rule and control; no clearing pass.
// A stalled result holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module quad_path_winding_test (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i,     // fill_rule
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [191:0]  s_axis_tdata,   // point_x, point_y, start_x, start_y,
                                        // ctrl_x, ctrl_y, end_x, end_y
  input  logic [1:0]    s_axis_tuser,   // is_straight, first_elem
  input  logic          s_axis_tlast,   // last_elem
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata    // inside_res, winding, zero pad
);

  localparam int CW = qpw_pkg::CW;
  localparam int DW = qpw_pkg::DW;
  localparam int NW = qpw_pkg::NW;
  localparam int TW = qpw_pkg::TW;
  localparam int MA = qpw_pkg::MA;
  localparam int MB = qpw_pkg::MB;
  localparam int PW = qpw_pkg::PW;
  localparam int WW = qpw_pkg::WW;
  localparam int TF = qpw_pkg::TF;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_PREP = 12'b000000000010,
    S_LM1  = 12'b000000000100,
    S_LM2  = 12'b000000001000,
    S_QB1  = 12'b000000010000,
    S_QB2  = 12'b000000100000,
    S_SQRT = 12'b000001000000,
    S_DIV  = 12'b000010000000,
    S_EVAL = 12'b000100000000,
    S_TY1  = 12'b001000000000,
    S_TY2  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_e;

  localparam logic [2:0] EV_RR  = 3'd0;
  localparam logic [2:0] EV_SX  = 3'd1;
  localparam logic [2:0] EV_TR  = 3'd2;
  localparam logic [2:0] EV_CX  = 3'd3;
  localparam logic [2:0] EV_TT  = 3'd4;
  localparam logic [2:0] EV_EX  = 3'd5;

  state_e                 state_q, state_d;
  logic                   fill_q;
  logic signed [CW-1:0]   px_q, py_q, sx_q, sy_q, cx_q, cy_q, ex_q, ey_q;
  logic                   straight_q, last_q;
  logic signed [PW-1:0]   acc_q, acc_d;
  logic signed [MA-1:0]   tmp_q, tmp_d;
  logic signed [WW-1:0]   wind_q, wind_d;
  logic [TW-1:0]          t0_q, t0_d, t1_q, t1_d, thit_q, thit_d;
  logic [1:0]             n_q, n_d;
  logic                   ridx_q, ridx_d, rsel_q, rsel_d, two_q, two_d;
  logic                   odd_q, odd_d;
  logic [2:0]             step_q, step_d;
  logic                   ovalid_q, ovalid_d, oin_q, oin_d;
  logic signed [WW-1:0]   owind_q, owind_d;

  logic                   in_acc;
  logic signed [DW-1:0]   d0, d1, d2, py_sy, ex_sx, px_sx, ey_sy, cy_sy, ey_cy;
  logic signed [NW-1:0]   a_coef, num_lin, den_lin, num_lo, num_hi;
  logic signed [NW-1:0]   dv_num, dv_den;
  logic signed [CW-1:0]   line_lo, line_hi, quad_lo, quad_hi;
  logic                   line_hit, quad_hit;
  logic signed [MA-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [PW-1:0]   prod, acc_sum, acc_dif, pref;
  logic [TW-1:0]          t_cur, t_op, r_op;
  logic                   sq_start, dv_start, dv_take;
  logic [1:0]             n_new;
  qpw_pkg::sq_res_t       sq_res;
  qpw_pkg::dv_res_t       dv_res;

  qpw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (acc_dif[qpw_pkg::SQW-1:0]),
    .res_o   (sq_res)
  );

  qpw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .res_o   (dv_res)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign d0    = DW'(sy_q) - DW'(py_q);
  assign d1    = DW'(cy_q) - DW'(py_q);
  assign d2    = DW'(ey_q) - DW'(py_q);
  assign py_sy = DW'(py_q) - DW'(sy_q);
  assign ex_sx = DW'(ex_q) - DW'(sx_q);
  assign px_sx = DW'(px_q) - DW'(sx_q);
  assign ey_sy = DW'(ey_q) - DW'(sy_q);
  assign cy_sy = DW'(cy_q) - DW'(sy_q);
  assign ey_cy = DW'(ey_q) - DW'(cy_q);

  assign a_coef  = NW'(d0) - NW'(d1) - NW'(d1) + NW'(d2);
  assign num_lin = NW'(d2) - NW'(d1) - NW'(d1);
  assign den_lin = NW'(d2) - NW'(d1) + NW'(d2) - NW'(d1);
  assign num_lo  = NW'(d0) - NW'(d1) - $signed({2'b00, sq_res.root});
  assign num_hi  = NW'(d0) - NW'(d1) + $signed({2'b00, sq_res.root});

  assign line_lo  = (ey_q < sy_q) ? ey_q : sy_q;
  assign line_hi  = (ey_q < sy_q) ? sy_q : ey_q;
  assign quad_lo  = (cy_q < line_lo) ? cy_q : line_lo;
  assign quad_hi  = (cy_q > line_hi) ? cy_q : line_hi;
  assign line_hit = !(py_q < line_lo || py_q >= line_hi || line_lo == line_hi);
  assign quad_hit = !(py_q < quad_lo || py_q >= quad_hi);

  assign t_cur = rsel_q ? t1_q : t0_q;
  assign t_op  = (state_q == S_EVAL) ? t_cur : thit_q;
  assign r_op  = qpw_pkg::T_ONE - t_op;

  assign prod    = mul_a * mul_b;
  assign acc_sum = acc_q + prod;
  assign acc_dif = acc_q - prod;
  assign pref    = $signed({{(PW-CW-2*TF){px_q[CW-1]}}, px_q, {(2*TF){1'b0}}});

  assign dv_take = dv_res.ok && !(n_q == 2'd1 && dv_res.q == t0_q);
  assign n_new   = dv_take ? n_q + 2'd1 : n_q;

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    tmp_d    = tmp_q;
    wind_d   = wind_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    thit_d   = thit_q;
    n_d      = n_q;
    ridx_d   = ridx_q;
    rsel_d   = rsel_q;
    two_d    = two_q;
    odd_d    = odd_q;
    step_d   = step_q;
    ovalid_d = ovalid_q;
    oin_d    = oin_q;
    owind_d  = owind_q;
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    dv_num   = num_lin;
    dv_den   = den_lin;
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_PREP;
          if (s_axis_tuser[1]) begin
            wind_d = '0;
          end
        end
      end
      S_PREP: begin
        n_d    = '0;
        ridx_d = 1'b0;
        rsel_d = 1'b0;
        odd_d  = 1'b0;
        step_d = EV_RR;
        if (straight_q) begin
          state_d = line_hit ? S_LM1 : S_DONE;
        end else begin
          state_d = quad_hit ? S_QB1 : S_DONE;
        end
      end
      S_LM1: begin
        mul_a   = MA'(py_sy);
        mul_b   = MB'(ex_sx);
        acc_d   = prod;
        state_d = S_LM2;
      end
      S_LM2: begin
        mul_a = MA'(px_sx);
        mul_b = MB'(ey_sy);
        if ((ey_q > sy_q) ? (acc_q <= prod) : (acc_q >= prod)) begin
          wind_d = qpw_pkg::wind_step(wind_q, ey_q < sy_q);
        end
        state_d = S_DONE;
      end
      S_QB1: begin
        mul_a   = MA'(d1);
        mul_b   = MB'(d1);
        acc_d   = prod;
        state_d = S_QB2;
      end
      S_QB2: begin
        mul_a = MA'(d0);
        mul_b = MB'(d2);
        if (a_coef != '0) begin
          if (!acc_dif[PW-1]) begin
            sq_start = 1'b1;
            two_d    = 1'b1;
            state_d  = S_SQRT;
          end else begin
            state_d = S_DONE;
          end
        end else if (d1 != d2) begin
          dv_start = 1'b1;
          two_d    = 1'b0;
          state_d  = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SQRT: begin
        dv_num = num_lo;
        dv_den = a_coef;
        if (sq_res.done) begin
          dv_start = 1'b1;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        dv_num = num_hi;
        dv_den = a_coef;
        if (dv_res.done) begin
          if (dv_take) begin
            if (n_q == '0) begin
              t0_d = dv_res.q;
            end else begin
              t1_d = dv_res.q;
            end
          end
          n_d = n_new;
          if (two_q && !ridx_q) begin
            ridx_d   = 1'b1;
            dv_start = 1'b1;
          end else begin
            state_d = (n_new != '0) ? S_EVAL : S_DONE;
          end
        end
      end
      S_EVAL: begin
        step_d = step_q + 3'd1;
        case (step_q)
          EV_RR: begin
            mul_a = $signed({{(MA-TW){1'b0}}, r_op});
            mul_b = $signed({{(MB-TW){1'b0}}, r_op});
            tmp_d = prod[MA-1:0];
          end
          EV_SX: begin
            mul_a = tmp_q;
            mul_b = MB'(sx_q);
            acc_d = prod;
          end
          EV_TR: begin
            mul_a = $signed({{(MA-TW-1){1'b0}}, t_op, 1'b0});
            mul_b = $signed({{(MB-TW){1'b0}}, r_op});
            tmp_d = prod[MA-1:0];
          end
          EV_CX: begin
            mul_a = tmp_q;
            mul_b = MB'(cx_q);
            acc_d = acc_sum;
          end
          EV_TT: begin
            mul_a = $signed({{(MA-TW){1'b0}}, t_op});
            mul_b = $signed({{(MB-TW){1'b0}}, t_op});
            tmp_d = prod[MA-1:0];
          end
          EV_EX: begin
            mul_a  = tmp_q;
            mul_b  = MB'(ex_q);
            step_d = EV_RR;
            if (acc_sum <= pref) begin
              odd_d  = !odd_q;
              thit_d = t_cur;
            end
            if (!rsel_q && n_q == 2'd2) begin
              rsel_d = 1'b1;
            end else begin
              state_d = ((acc_sum <= pref) ? !odd_q : odd_q) ? S_TY1 : S_DONE;
            end
          end
          default: begin
            step_d = EV_RR;
          end
        endcase
      end
      S_TY1: begin
        mul_a   = $signed({{(MA-TW){1'b0}}, r_op});
        mul_b   = MB'(cy_sy);
        acc_d   = prod;
        state_d = S_TY2;
      end
      S_TY2: begin
        mul_a   = $signed({{(MA-TW){1'b0}}, t_op});
        mul_b   = MB'(ey_cy);
        wind_d  = qpw_pkg::wind_step(wind_q, acc_sum[PW-1]);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          owind_d  = wind_q;
          oin_d    = fill_q ? (wind_q != '0) : wind_q[0];
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= 1'b0;
      wind_q   <= '0;
      ovalid_q <= 1'b0;
      n_q      <= '0;
      ridx_q   <= 1'b0;
      rsel_q   <= 1'b0;
      two_q    <= 1'b0;
      odd_q    <= 1'b0;
      step_q   <= EV_RR;
    end else begin
      state_q  <= state_d;
      wind_q   <= wind_d;
      ovalid_q <= ovalid_d;
      n_q      <= n_d;
      ridx_q   <= ridx_d;
      rsel_q   <= rsel_d;
      two_q    <= two_d;
      odd_q    <= odd_d;
      step_q   <= step_d;
      if (cfg_valid_i) begin
        fill_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    tmp_q   <= tmp_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    thit_q  <= thit_d;
    oin_q   <= oin_d;
    owind_q <= owind_d;
    if (in_acc) begin
      px_q       <= s_axis_tdata[23:0];
      py_q       <= s_axis_tdata[47:24];
      sx_q       <= s_axis_tdata[71:48];
      sy_q       <= s_axis_tdata[95:72];
      cx_q       <= s_axis_tdata[119:96];
      cy_q       <= s_axis_tdata[143:120];
      ex_q       <= s_axis_tdata[167:144];
      ey_q       <= s_axis_tdata[191:168];
      straight_q <= s_axis_tuser[0];
      last_q     <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'b0, owind_q, oin_q};

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_PREP)
    else $error("accepted item did not start");
  a_eval_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> n_q != '0)
    else $error("evaluating with no root");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !s_axis_tvalid) |=> $stable(wind_q))
    else $error("count moved while idle");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: winding count point in path test bench
// Drives paths of lines and quadratic curves around a query point,
// predicts the verdict and count per path, checks every result item in order.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic signed [23:0] ey, ex, cy, cx, sy, sx, py, px;
    logic               straight;
    logic               first;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic               in_path;
    logic signed [15:0] winding;
  } verdict_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;  // px, py, sx, sy, cx, cy, ex, ey
  logic [1:0]   s_axis_tuser = '0;  // is_straight, first_elem
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;       // inside_res, winding, zero pad

  verdict_t verdict_q[$];
  longint   wind_acc;
  bit       fill_nonzero;
  bit       idle_en;
  int       errors;
  int       stall_cnt;

  quad_path_winding_test u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------- winding predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit crossing_t(longint num, longint den, output longint t);
    longint q;
    t = 0;
    if (den == 0) return 1'b0;
    q = (num * (64'sd1 <<< qpw_pkg::TF)) / den;
    if (q < 0 || q > (64'sd1 <<< qpw_pkg::TF)) return 1'b0;
    t = q;
    return 1'b1;
  endfunction

  function automatic void bump_winding(longint d);
    wind_acc = wind_acc + d;
    if (wind_acc > 32767) wind_acc = 32767;
    if (wind_acc < -32768) wind_acc = -32768;
  endfunction

  function automatic void predict_winding(elem_t e);
    longint px, py, sx, sy, cx, cy, ex, ey, lo, hi, dir;
    longint d0, d1, d2, a, b, s, t, r, x, ty, thit;
    longint ts[2];
    int n;
    bit odd;
    verdict_t v;
    px = e.px; py = e.py; sx = e.sx; sy = e.sy;
    cx = e.cx; cy = e.cy; ex = e.ex; ey = e.ey;
    if (e.first) wind_acc = 0;
    lo = sy; hi = ey; dir = 1;
    if (ey < sy) begin
      lo = ey; hi = sy; dir = -1;
    end
    if (e.straight) begin
      if (!(py < lo || py >= hi || lo == hi)) begin
        a = (py - sy) * (ex - sx);
        b = (px - sx) * (ey - sy);
        if ((ey > sy) ? (a <= b) : (a >= b)) bump_winding(dir);
      end
    end else begin
      if (cy < lo) lo = cy;
      if (cy > hi) hi = cy;
      if (!(py < lo || py >= hi)) begin
        d0 = sy - py; d1 = cy - py; d2 = ey - py;
        a = d0 - 2 * d1 + d2;
        n = 0;
        odd = 0;
        thit = 0;
        if (a != 0) begin
          b = d1 * d1 - d0 * d2;
          if (b >= 0) begin
            s = longint'(int_sqrt(b));
            if (crossing_t(d0 - d1 - s, a, t)) begin
              ts[n] = t; n++;
            end
            if (crossing_t(d0 - d1 + s, a, t) && !(n == 1 && t == ts[0])) begin
              ts[n] = t; n++;
            end
          end
        end else if (d1 != d2) begin
          if (crossing_t(d2 - 2 * d1, 2 * (d2 - d1), t)) begin
            ts[n] = t; n++;
          end
        end
        for (int i = 0; i < n; i++) begin
          r = (64'sd1 <<< qpw_pkg::TF) - ts[i];
          x = r * r * sx + 2 * ts[i] * r * cx + ts[i] * ts[i] * ex;
          if (x <= px * (64'sd1 <<< (2 * qpw_pkg::TF))) begin
            odd = !odd;
            thit = ts[i];
          end
        end
        if (odd) begin
          r = (64'sd1 <<< qpw_pkg::TF) - thit;
          ty = r * (cy - sy) + thit * (ey - cy);
          bump_winding(ty < 0 ? -1 : 1);
        end
      end
    end
    if (e.last) begin
      v.in_path = fill_nonzero ? (wind_acc != 0) : wind_acc[0];
      v.winding = wind_acc[15:0];
      verdict_q.push_back(v);
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_elem(elem_t e);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e.ey, e.ex, e.cy, e.cx, e.sy, e.sx, e.py, e.px};
    s_axis_tuser  <= {e.first, e.straight};
    s_axis_tlast  <= e.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_winding(e);
  endtask

  task automatic write_fill_rule(bit v);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fill_nonzero = v;
  endtask

  function automatic elem_t mk(int px, int py, int sx, int sy, int cx, int cy,
                               int ex, int ey, bit st, bit f, bit l);
    elem_t e;
    e = {24'(ey), 24'(ex), 24'(cy), 24'(cx), 24'(sy), 24'(sx), 24'(py), 24'(px),
         st, f, l};
    return e;
  endfunction

  function automatic int rcoord(int span);
    if (span >= 23) return int'($signed(24'($urandom)));
    return $signed($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span);
  endfunction

  // ---------------- tests ----------------
  task automatic test_lines_directed();
    send_elem(mk(0, 0, -100, -10, 0, 0, -100, 10, 1, 1, 0));   // up, left
    send_elem(mk(0, 0, 100, 10, 0, 0, 100, -10, 1, 0, 0));     // down, right
    send_elem(mk(0, 0, -50, 0, 0, 0, 50, 0, 1, 0, 0));         // horizontal
    send_elem(mk(0, 0, 0, -10, 0, 0, 0, 10, 1, 0, 0));         // through point
    send_elem(mk(0, 0, -5, 0, 0, 0, -5, 10, 1, 0, 1));         // vertex at py
    send_elem(mk(-8388608, -8388608, 8388607, -8388608, 0, 0,
                 -8388608, 8388607, 1, 1, 1));
    send_elem(mk(8388607, 8388607, -8388608, 8388607, 0, 0,
                 8388607, -8388608, 1, 1, 1));
  endtask

  task automatic test_curves_directed();
    send_elem(mk(0, 0, -100, -100, -300, 0, -100, 100, 0, 1, 0)); // a == 0
    send_elem(mk(0, 0, 100, -100, 300, 50, 100, 100, 0, 0, 1));
    send_elem(mk(0, 0, -100, -100, 0, 100, 100, -100, 0, 1, 1));  // tangent, double root
    send_elem(mk(0, 0, -100, 10, 0, 100, 100, 10, 0, 1, 1));      // above py
    send_elem(mk(0, 5, -100, 5, 0, 5, 100, 5, 0, 1, 1));          // flat
    send_elem(mk(0, 0, -100, 0, -50, -100, -100, 0, 0, 1, 1));    // both ends at py
    send_elem(mk(0, 0, -8388608, -8388608, 8388607, 8388607,
                 -8388608, 8388607, 0, 1, 1));
    send_elem(mk(-1, 0, 8388607, 8388607, -8388608, -8388608,
                 8388607, -8388608, 0, 1, 1));
  endtask

  task automatic test_count_runs(bit down);
    for (int i = 0; i < 40; i++)
      send_elem(mk(0, 0, -100, down ? 10 : -10, 0, 0, -100, down ? -10 : 10,
                   1, i == 0, i == 39));
    send_elem(mk(0, 0, -100, down ? -10 : 10, 0, 0, -100, down ? 10 : -10,
                 1, 0, 1));
  endtask

  task automatic test_random_paths(int items);
    int sent, nv, span, cx0, cy0;
    int vx[8], vy[8];
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_elem(elem_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, 3'($urandom)}));
        sent++;
      end else begin
        span = ($urandom_range(0, 9) == 0) ? 23 : $urandom_range(3, 14);
        cx0 = rcoord(span > 20 ? 20 : span);
        cy0 = rcoord(span > 20 ? 20 : span);
        nv = $urandom_range(1, 6);
        for (int i = 0; i < nv; i++) begin
          vx[i] = rcoord(span);
          vy[i] = rcoord(span);
        end
        if ($urandom_range(0, 3) == 0) begin
          vx[0] = cx0;
          vy[0] = cy0;
        end
        for (int i = 0; i < nv; i++) begin
          send_elem(mk(cx0, cy0, vx[i], vy[i], rcoord(span), rcoord(span),
                       vx[(i + 1) % nv], vy[(i + 1) % nv], $urandom_range(0, 1),
                       i == 0 || $urandom_range(0, 30) == 0,
                       i == nv - 1 || $urandom_range(0, 20) == 0));
          sent++;
        end
      end
    end
  endtask

  // ---------------- result sink ----------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    verdict_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.in_path = m_axis_tdata[0];
      got.winding = m_axis_tdata[16:1];
      if (verdict_q.size() == 0) begin
        $error("result item with no expectation: %h", m_axis_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got.in_path !== want.in_path) begin
          $error("inside_res: expected %0d actual %0d", want.in_path, got.in_path);
          errors++;
        end
        if (got.winding !== want.winding) begin
          $error("winding: expected %0d actual %0d", want.winding, got.winding);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 3000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    errors = 0;
    wind_acc = 0;
    fill_nonzero = 0;
    idle_en = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_fill_rule(0);
    test_lines_directed();
    test_curves_directed();
    write_fill_rule(1);
    test_lines_directed();
    test_curves_directed();
    idle_en = 0;
    test_count_runs(0);
    test_count_runs(1);
    idle_en = 1;
    test_random_paths(190);
    write_fill_rule(0);
    test_random_paths(190);
    write_fill_rule(1);
    test_random_paths(100);
    idle_en = 0;
    test_random_paths(90);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/qpw_pkg.sv
design/qpw_sqrt.sv
design/qpw_div.sv
design/quad_path_winding_test.sv
tb/tb_top.sv
